/* design/lbat_pkg.sv */
package lbat_pkg;

    localparam int SENSOR_W  = 10;
    localparam int TICK_W    = 16;
    localparam int LEVEL_W   = 8;
    localparam int STATUS_W  = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int HIST_N    = 3;

    localparam logic [TICK_W-1:0] HISTORY_PERIOD_TICKS = 16'd5;
    localparam logic [TICK_W-1:0] TICK_MAX             = 16'hFFFF;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_LOCK = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_IDLE_SMALL = 4'd0,
        ST_IDLE_DARK  = 4'd1,
        ST_STARTED    = 4'd2,
        ST_RUNNING    = 4'd3,
        ST_REACHED    = 4'd4,
        ST_LOW_LIGHT  = 4'd5,
        ST_WRONG_DIR  = 4'd6,
        ST_LONG_RUN   = 4'd7,
        ST_LOCKED     = 4'd8
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_LEVEL     = 3'd0,
        REG_START_MIN_DIFF  = 3'd1,
        REG_LONG_RUN_TICKS  = 3'd2,
        REG_LONG_RUN_MARGIN = 3'd3,
        REG_GROWTH_MARGIN   = 3'd4,
        REG_TIMEOUT_TICKS   = 3'd5,
        REG_DIRECTION_SENSE = 3'd6,
        REG_DRIVE_SPEED     = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [SENSOR_W-1:0] start_level;
        logic [SENSOR_W-1:0] start_min_diff;
        logic [TICK_W-1:0]   long_run_ticks;
        logic [SENSOR_W-1:0] long_run_margin;
        logic [SENSOR_W-1:0] growth_margin;
        logic [TICK_W-1:0]   timeout_ticks;
        logic                direction_sense;
        logic [LEVEL_W-1:0]  drive_speed;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        start_level:     10'd1012,
        start_min_diff:  10'd3,
        long_run_ticks:  16'd50,
        long_run_margin: 10'd4,
        growth_margin:   10'd3,
        timeout_ticks:   16'd1200,
        direction_sense: 1'b1,
        drive_speed:     8'd255
    };

    typedef struct packed {
        mode_t                           mode;
        logic                            start_negative;
        logic [TICK_W-1:0]               elapsed_ticks;
        logic [HIST_N-1:0][TICK_W-1:0]   history_time;
        logic [HIST_N-1:0][SENSOR_W-1:0] history_diff;
        logic [HIST_N-1:0]               history_valid;
        logic                            direction_hold;
    } state_t;

    localparam state_t STATE_RESET = '{
        mode:           MODE_IDLE,
        start_negative: 1'b0,
        elapsed_ticks:  '0,
        history_time:   '0,
        history_diff:   '0,
        history_valid:  '0,
        direction_hold: 1'b0
    };

    typedef struct packed {
        logic [LEVEL_W-1:0] drive_level;
        logic               motor_direction;
        status_t            status;
    } result_t;

endpackage

/* design/lbat_in_if.sv */
interface lbat_in_if;
    logic                           valid;
    logic                           ready;
    logic [lbat_pkg::SENSOR_W-1:0]  sensor_a;
    logic [lbat_pkg::SENSOR_W-1:0]  sensor_b;

    modport source (output valid, output sensor_a, output sensor_b, input ready);
    modport sink   (input valid, input sensor_a, input sensor_b, output ready);
endinterface

/* design/lbat_out_if.sv */
interface lbat_out_if;
    logic                           valid;
    logic                           ready;
    logic [lbat_pkg::LEVEL_W-1:0]   drive_level;
    logic                           motor_direction;
    logic [lbat_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output drive_level, output motor_direction,
                    output status, input ready);
    modport sink   (input valid, input drive_level, input motor_direction,
                    input status, output ready);
endinterface

/* design/light_balance_axis_tracker.sv */
// channel   role  handshake       payload
// sensors   sink  valid / ready   sensor_a[9:0], sensor_b[9:0]
// result    src   valid / ready   drive_level[7:0], motor_direction, status[3:0]
// cfg       in    cfg_we          cfg_index[2:0], cfg_data[15:0]
//
// Two register stages: input word register, then the control step into the
// result register. One word per cycle sustained while the result side is ready.
// The control state is updated when a word moves into the result register.
// A stalled result holds both stages; each stage refills in the cycle it drains.
// rst_n clears control state, the valid flags and the config registers to defaults.
module light_balance_axis_tracker (
    input  logic                            clk,
    input  logic                            rst_n,
    lbat_in_if.sink                         sensors,
    lbat_out_if.source                      result,
    input  logic                            cfg_we,
    input  logic [lbat_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lbat_pkg::CFG_W-1:0]      cfg_data
);

    lbat_pkg::cfg_t                 cfg_reg;
    lbat_pkg::state_t               state_reg;
    lbat_pkg::state_t               state_next;
    lbat_pkg::result_t              res_next;
    lbat_pkg::result_t              res_reg;
    logic                           res_valid_reg;
    logic                           in_valid_reg;
    logic [lbat_pkg::SENSOR_W-1:0]  a_reg;
    logic [lbat_pkg::SENSOR_W-1:0]  b_reg;
    logic                           step;
    logic                           take;

    assign step          = in_valid_reg && (!res_valid_reg || result.ready);
    assign take          = sensors.valid && sensors.ready;
    assign sensors.ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= lbat_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (lbat_pkg::reg_index_t'(cfg_index))
                lbat_pkg::REG_START_LEVEL:
                    cfg_reg.start_level <= cfg_data[lbat_pkg::SENSOR_W-1:0];
                lbat_pkg::REG_START_MIN_DIFF:
                    cfg_reg.start_min_diff <= cfg_data[lbat_pkg::SENSOR_W-1:0];
                lbat_pkg::REG_LONG_RUN_TICKS:
                    cfg_reg.long_run_ticks <= cfg_data;
                lbat_pkg::REG_LONG_RUN_MARGIN:
                    cfg_reg.long_run_margin <= cfg_data[lbat_pkg::SENSOR_W-1:0];
                lbat_pkg::REG_GROWTH_MARGIN:
                    cfg_reg.growth_margin <= cfg_data[lbat_pkg::SENSOR_W-1:0];
                lbat_pkg::REG_TIMEOUT_TICKS:
                    cfg_reg.timeout_ticks <= cfg_data;
                lbat_pkg::REG_DIRECTION_SENSE:
                    cfg_reg.direction_sense <= cfg_data[0];
                lbat_pkg::REG_DRIVE_SPEED:
                    cfg_reg.drive_speed <= cfg_data[lbat_pkg::LEVEL_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sensors.ready)
        begin
            in_valid_reg <= sensors.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_reg <= sensors.sensor_a;
            b_reg <= sensors.sensor_b;
        end
    end

    lbat_core u_core (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .sensor_a   (a_reg),
        .sensor_b   (b_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lbat_pkg::STATE_RESET;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid           = res_valid_reg;
    assign result.drive_level     = res_reg.drive_level;
    assign result.motor_direction = res_reg.motor_direction;
    assign result.status          = res_reg.status;

endmodule

/* design/lbat_core.sv */
module lbat_core (
    input  lbat_pkg::cfg_t                  cfg,
    input  lbat_pkg::state_t                state,
    input  logic [lbat_pkg::SENSOR_W-1:0]   sensor_a,
    input  logic [lbat_pkg::SENSOR_W-1:0]   sensor_b,
    output lbat_pkg::state_t                state_next,
    output lbat_pkg::result_t               result
);

    logic [lbat_pkg::SENSOR_W-1:0] diff;
    logic                          a_lt_b;
    logic                          a_gt_b;
    logic [lbat_pkg::TICK_W-1:0]   elapsed_inc;
    logic [lbat_pkg::TICK_W-1:0]   since_hist;
    logic                          hist_shift;
    lbat_pkg::state_t              run_state;
    logic [lbat_pkg::SENSOR_W:0]   wrong_limit;
    logic [lbat_pkg::SENSOR_W:0]   a_plus_margin;
    logic [lbat_pkg::SENSOR_W:0]   b_plus_margin;
    logic                          wrong_dir;
    logic                          timed_out;
    logic                          long_run;
    logic                          leads;
    logic                          ahead;
    logic                          bright;

    assign a_lt_b = sensor_a < sensor_b;
    assign a_gt_b = sensor_a > sensor_b;
    assign diff   = a_lt_b ? (sensor_b - sensor_a) : (sensor_a - sensor_b);

    assign elapsed_inc = (state.elapsed_ticks != lbat_pkg::TICK_MAX)
                         ? state.elapsed_ticks + 16'd1 : state.elapsed_ticks;
    assign since_hist  = elapsed_inc - state.history_time[0];
    assign hist_shift  = since_hist >= lbat_pkg::HISTORY_PERIOD_TICKS;

    always_comb
    begin
        run_state               = state;
        run_state.elapsed_ticks = elapsed_inc;
        if (hist_shift)
        begin
            run_state.history_time  = {state.history_time[1:0], elapsed_inc};
            run_state.history_diff  = {state.history_diff[1:0], diff};
            run_state.history_valid = {state.history_valid[1:0], 1'b1};
        end
    end

    assign wrong_limit   = {1'b0, run_state.history_diff[2]} + {1'b0, cfg.growth_margin};
    assign wrong_dir     = run_state.history_valid[2] &&
                           ({1'b0, run_state.history_diff[0]} > wrong_limit);
    assign timed_out     = elapsed_inc > cfg.timeout_ticks;
    assign long_run      = elapsed_inc > cfg.long_run_ticks;
    assign a_plus_margin = {1'b0, sensor_a} + {1'b0, cfg.long_run_margin};
    assign b_plus_margin = {1'b0, sensor_b} + {1'b0, cfg.long_run_margin};
    assign leads         = state.start_negative ? (a_plus_margin < {1'b0, sensor_b})
                                                : ({1'b0, sensor_a} > b_plus_margin);
    assign ahead         = state.start_negative ? a_lt_b : a_gt_b;
    assign bright        = (sensor_a > cfg.start_level) || (sensor_b > cfg.start_level);

    always_comb
    begin
        state_next             = state;
        result.drive_level     = '0;
        result.motor_direction = state.direction_hold;
        result.status          = lbat_pkg::ST_LOCKED;
        case (state.mode)
            lbat_pkg::MODE_IDLE:
            begin
                if (diff == '0 || diff < cfg.start_min_diff)
                begin
                    result.status = lbat_pkg::ST_IDLE_SMALL;
                end
                else if (sensor_a < cfg.start_level && sensor_b < cfg.start_level)
                begin
                    result.status = lbat_pkg::ST_IDLE_DARK;
                end
                else
                begin
                    state_next.mode           = lbat_pkg::MODE_RUN;
                    state_next.start_negative = a_lt_b;
                    state_next.direction_hold = cfg.direction_sense ^ a_lt_b;
                    state_next.elapsed_ticks  = '0;
                    state_next.history_time   = '0;
                    state_next.history_diff   = {{(2*lbat_pkg::SENSOR_W){1'b0}}, diff};
                    state_next.history_valid  = 3'b001;
                    result.motor_direction    = cfg.direction_sense ^ a_lt_b;
                    result.drive_level        = cfg.drive_speed;
                    result.status             = lbat_pkg::ST_STARTED;
                end
            end
            lbat_pkg::MODE_RUN:
            begin
                state_next = run_state;
                if (wrong_dir)
                begin
                    state_next.mode = lbat_pkg::MODE_IDLE;
                    result.status   = lbat_pkg::ST_WRONG_DIR;
                end
                else if (timed_out)
                begin
                    state_next.mode = lbat_pkg::MODE_LOCK;
                    result.status   = lbat_pkg::ST_LOCKED;
                end
                else if (long_run && !leads)
                begin
                    state_next.mode = lbat_pkg::MODE_IDLE;
                    result.status   = lbat_pkg::ST_LONG_RUN;
                end
                else if (!ahead)
                begin
                    state_next.mode = lbat_pkg::MODE_IDLE;
                    result.status   = lbat_pkg::ST_REACHED;
                end
                else if (!bright)
                begin
                    state_next.mode = lbat_pkg::MODE_IDLE;
                    result.status   = lbat_pkg::ST_LOW_LIGHT;
                end
                else
                begin
                    result.drive_level = cfg.drive_speed;
                    result.status      = lbat_pkg::ST_RUNNING;
                end
            end
            default:
            begin
                state_next.mode = lbat_pkg::MODE_LOCK;
            end
        endcase
    end

endmodule
